// File: hw/rtl/ddf_pkg.sv
`default_nettype none

package ddf_pkg;

  // digit and value sizes
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned VALUE_BITS = 32;

  // field widths on the channels
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 4;
  localparam int unsigned ColW    = 8;
  localparam int unsigned RowW    = 3;
  localparam int unsigned FontW   = 8;
  localparam int unsigned CharW   = 6;

  // derived sizes
  localparam int unsigned DigIdxW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned BitCntW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  localparam logic [CharW-1:0] CharSpace = CharW'(8'h20);
  localparam logic [CharW-1:0] CharZero  = CharW'(8'h30);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } ddf_state_e;

endpackage

`default_nettype wire

// File: hw/rtl/ddf_in_if.sv
`default_nettype none

interface ddf_in_if
  import ddf_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] value;
  logic [CountW-1:0] digit_count;
  logic [ColW-1:0]   start_column;
  logic [RowW-1:0]   page_row;
  logic [FontW-1:0]  font_size;

  modport source (
    output valid, value, digit_count, start_column, page_row, font_size,
    input  ready
  );

  modport sink (
    input  valid, value, digit_count, start_column, page_row, font_size,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/ddf_out_if.sv
`default_nettype none

interface ddf_out_if
  import ddf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic [ColW-1:0]  column;
  logic [RowW-1:0]  row_out;
  logic             last;

  modport source (
    output valid, char_code, column, row_out, last,
    input  ready
  );

  modport sink (
    input  valid, char_code, column, row_out, last,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/decimal_digit_formatter.sv
`default_nettype none

// channel   dir  modport  payload
// in_i      in   sink     value, digit_count, start_column, page_row, font_size
// out_o     out  source   char_code, column, row_out, last
//
// one number at a time: the value is converted by a shift-and-add-3 register,
// one value bit per cycle, all VALUE_BITS (32) bits, then one character per
// cycle while out_o is ready, digit_count characters (up to 10)
// a digit_count of 0 emits no characters
// in_i is ready only while no number is being converted or emitted
// a stall on out_o holds the current character; rst_ni clears the control state

module decimal_digit_formatter
  import ddf_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ddf_in_if.sink      in_i,
  ddf_out_if.source   out_o
);

  ddf_state_e state_q, state_d;

  logic [VALUE_BITS-1:0]            val_q, val_d;
  logic [MAX_DIGITS-1:0][3:0]       bcd_q, bcd_d;
  logic [BitCntW-1:0]               bit_q, bit_d;
  logic [DigIdxW-1:0]               idx_q, idx_d;
  logic                             shown_q, shown_d;
  logic [ColW-1:0]                  col_q, col_d;
  logic [ColW-1:0]                  step_q, step_d;
  logic [RowW-1:0]                  row_q, row_d;

  logic [CountW-1:0]                cnt_sat;
  logic [3:0]                       cur_dig;
  logic                             fin_dig;
  logic                             blank;
  logic [CharW-1:0]                 code;
  logic [MAX_DIGITS-1:0][3:0]       bcd_adj;

  assign cnt_sat = (in_i.digit_count > CountW'(MAX_DIGITS)) ? CountW'(MAX_DIGITS)
                                                             : in_i.digit_count;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  assign cur_dig = bcd_q[idx_q];
  assign fin_dig = (idx_q == '0);
  assign blank   = !shown_q && !fin_dig && (cur_dig == 4'd0);
  assign code    = blank ? CharSpace : CharZero + CharW'(cur_dig);

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = (state_q == ST_EMIT);
  assign out_o.char_code = code;
  assign out_o.column    = col_q;
  assign out_o.row_out   = row_q;
  assign out_o.last      = fin_dig;

  always_comb begin
    state_d = state_q;
    val_d   = val_q;
    bcd_d   = bcd_q;
    bit_d   = bit_q;
    idx_d   = idx_q;
    shown_d = shown_q;
    col_d   = col_q;
    step_d  = step_q;
    row_d   = row_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          val_d   = in_i.value[VALUE_BITS-1:0];
          bcd_d   = '0;
          bit_d   = BitCntW'(VALUE_BITS - 1);
          idx_d   = DigIdxW'(cnt_sat - CountW'(1));
          shown_d = 1'b0;
          col_d   = in_i.start_column;
          step_d  = ColW'(in_i.font_size >> 1);
          row_d   = in_i.page_row;
          if (cnt_sat != '0) begin
            state_d = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        for (int i = MAX_DIGITS - 1; i > 0; i--) begin
          bcd_d[i] = {bcd_adj[i][2:0], bcd_adj[i-1][3]};
        end
        bcd_d[0] = {bcd_adj[0][2:0], val_q[VALUE_BITS-1]};
        val_d    = val_q << 1;
        bit_d    = bit_q - BitCntW'(1);
        if (bit_q == '0) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_o.ready) begin
          shown_d = shown_q || !blank;
          col_d   = col_q + step_q;
          idx_d   = idx_q - DigIdxW'(1);
          if (fin_dig) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    bcd_q   <= bcd_d;
    bit_q   <= bit_d;
    idx_q   <= idx_d;
    shown_q <= shown_d;
    col_q   <= col_d;
    step_q  <= step_d;
    row_q   <= row_d;
  end

  a_no_accept_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !out_o.valid)
    else $error("input transfer while a character is pending");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.char_code == CharSpace ||
                     (out_o.char_code >= CharZero && out_o.char_code <= CharZero + 6'd9)))
    else $error("character code out of range");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last) |=> (state_q == ST_IDLE))
    else $error("emission continues after the last digit");

  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last) |=>
      (out_o.valid && out_o.column == ColW'($past(out_o.column) + $past(step_q))))
    else $error("column did not advance by one step");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (idx_q < DigIdxW'(MAX_DIGITS)))
    else $error("digit index beyond the digit register");

endmodule

`default_nettype wire
